/* rtl/core/ds_twr_ranging_engine_macros.svh */
// Assertion macros shared by the checker.
`ifndef DS_TWR_RANGING_ENGINE_MACROS_SVH
`define DS_TWR_RANGING_ENGINE_MACROS_SVH
`define DTR_ASSERT_IMPL(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define DTR_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* rtl/core/dtr_pkg.sv */
package dtr_pkg;
    localparam int TsW = 40;

    typedef enum logic [2:0] {
        FUNC_RX = 3'd0, FUNC_TX = 3'd1, FUNC_TMO = 3'd2, FUNC_START = 3'd3,
        FUNC_FAIL = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        FR_NONE = 3'd0, FR_POLL = 3'd1, FR_ANSWER = 3'd2, FR_FINAL = 3'd3,
        FR_REPORT = 3'd4
    } frame_t;

    localparam logic [7:0] MSG_POLL = 8'h01;
    localparam logic [7:0] MSG_ANSWER = 8'h02;
    localparam logic [7:0] MSG_FINAL = 8'h03;
    localparam logic [7:0] MSG_REPORT = 8'h04;

    localparam logic CFG_ANT_DELAY = 1'b0;
    localparam logic CFG_INTERVAL = 1'b1;

    // Millimetre scale: d = q * MmNum / MmDen.
    localparam logic [28:0] MmNum = 29'd299792458;
    localparam logic [33:0] MmDen = 34'd16357785600;

    typedef struct packed {
        logic [2:0]     func;
        logic [7:0]     msg_type;
        logic [7:0]     msg_seq;
        logic [TsW-1:0] event_time;
        logic [TsW-1:0] peer_poll_rx;
        logic [TsW-1:0] peer_answer_tx;
        logic [TsW-1:0] peer_final_rx;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        send_type;
        logic [7:0]        send_seq;
        logic [TsW-1:0]    send_poll_rx;
        logic [TsW-1:0]    send_answer_tx;
        logic [TsW-1:0]    send_final_rx;
        logic              range_valid;
        logic signed [31:0] prop_ticks_q8;
        logic signed [23:0] distance_mm;
        logic              restart_receive;
        logic [15:0]       next_timeout_ms;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_DIV, ST_MM, ST_MMDIV, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SR_MULT, SR_DIVQ8, SR_DIVMM
    } sr_op_t;

    typedef struct packed {
        logic   start;
        sr_op_t op;
    } sr_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sr_sts_t;
endpackage

/* rtl/core/dtr_serial_unit.sv */
module dtr_serial_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  dtr_pkg::sr_ctl_t  ctl,
    input  logic [71:0]       opa,
    input  logic [33:0]       opb,
    output dtr_pkg::sr_sts_t  sts,
    output logic [71:0]       res,
    output logic              big
);
    import dtr_pkg::*;

    // Bit-serial multiply (shift-add) and restoring divide, one bit per cycle.
    logic [71:0] acc_reg, acc_next;
    logic [71:0] a_reg, a_next;
    logic [34:0] rem_reg, rem_next;
    logic [33:0] b_reg, b_next;
    logic [6:0]  cnt_reg, cnt_next;
    sr_op_t      op_reg, op_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic        big_reg, big_next;
    logic [34:0] shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        a_reg <= a_next;
        rem_reg <= rem_next;
        b_reg <= b_next;
        cnt_reg <= cnt_next;
        op_reg <= op_next;
        big_reg <= big_next;
    end

    always_comb begin
        acc_next = acc_reg;
        a_next = a_reg;
        rem_next = rem_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        op_next = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        big_next = big_reg;
        shifted = {rem_reg[33:0], a_reg[71]};
        if (ctl.start) begin
            op_next = ctl.op;
            acc_next = '0;
            rem_next = '0;
            a_next = opa;
            b_next = opb;
            big_next = 1'b0;
            busy_next = 1'b1;
            cnt_next = (ctl.op == SR_MULT) ? 7'd34 : 7'd72;
        end else if (busy_reg) begin
            case (op_reg)
                SR_MULT: begin
                    if (b_reg[0]) begin
                        acc_next = acc_reg + a_reg;
                    end
                    a_next = {a_reg[70:0], 1'b0};
                    b_next = {1'b0, b_reg[33:1]};
                end
                default: begin
                    a_next = {a_reg[70:0], 1'b0};
                    if (shifted >= {1'b0, b_reg}) begin
                        rem_next = shifted - {1'b0, b_reg};
                        acc_next = {acc_reg[70:0], 1'b1};
                    end else begin
                        rem_next = shifted;
                        acc_next = {acc_reg[70:0], 1'b0};
                    end
                    if (acc_reg[71:32] != '0) begin
                        big_next = 1'b1;
                    end
                end
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign res = acc_reg;
    assign big = big_reg || (acc_reg[71:32] != '0);
endmodule

/* rtl/core/ds_twr_ranging_engine.sv */
// Channel   Direction  Ports
// input     in         s_valid, s_ready, s_item
// result    out        m_valid, m_ready, m_item
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data
// Each item yields one result item. A report with a nonzero denominator runs
// two multiplies, a Q8 divide, a millimetre multiply and a divide on the
// bit-serial multiply/divide unit. Reset is synchronous, active low.
// A new item is accepted once the engine is idle and the result register is free.
module ds_twr_ranging_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dtr_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output dtr_pkg::out_item_t m_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);
    import dtr_pkg::*;

    logic [15:0] ant_reg, intv_reg;
    logic [TsW-1:0] pst_reg, prt_reg, ast_reg, art_reg, fst_reg, frt_reg;
    logic [TsW-1:0] pst_next, prt_next, ast_next, art_next, fst_next, frt_next;
    frame_t pend_reg, pend_next;
    logic [7:0] seq_reg, seq_next;
    logic [15:0] tmo_reg, tmo_next;
    state_t state_reg, state_next;
    out_item_t res_reg, res_next;
    logic ov_reg, ov_next;
    logic [63:0] pa_reg, pa_next;
    logic neg_reg, neg_next;
    logic [33:0] den_reg, den_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] r1, r2, p1, p2;
    logic [TsW-1:0] half, rx_t, tx_t;
    logic [33:0] den_c;
    sr_ctl_t sr_ctl;
    sr_sts_t sr_sts;
    logic [71:0] sr_a, sr_res;
    logic [33:0] sr_b;
    logic sr_big;
    logic [63:0] mag;
    logic [31:0] qs;
    logic [71:0] dq;
    logic accept;

    dtr_serial_unit u_sr (
        .aclk(aclk), .aresetn(aresetn), .ctl(sr_ctl), .opa(sr_a), .opb(sr_b),
        .sts(sr_sts), .res(sr_res), .big(sr_big)
    );

    assign s_ready = (state_reg == ST_IDLE) && !ov_reg;
    assign accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid = ov_reg;
    assign m_item = res_reg;

    assign half = {24'd0, 1'b0, ant_reg[15:1]};
    assign rx_t = s_item.event_time - half;
    assign tx_t = s_item.event_time + half;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ant_reg <= 16'd32951;
            intv_reg <= 16'd4000;
            pst_reg <= '0; prt_reg <= '0; ast_reg <= '0;
            art_reg <= '0; fst_reg <= '0; frt_reg <= '0;
            pend_reg <= FR_NONE;
            seq_reg <= '0;
            tmo_reg <= '0;
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_ANT_DELAY) begin
                    ant_reg <= cfg_data;
                end else begin
                    intv_reg <= cfg_data;
                end
            end
            pst_reg <= pst_next; prt_reg <= prt_next; ast_reg <= ast_next;
            art_reg <= art_next; fst_reg <= fst_next; frt_reg <= frt_next;
            pend_reg <= pend_next;
            seq_reg <= seq_next;
            tmo_reg <= tmo_next;
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
        res_reg <= res_next;
        pa_reg <= pa_next;
        neg_reg <= neg_next;
        den_reg <= den_next;
        q_reg <= q_next;
    end

    always_comb begin
        r1 = art_reg[31:0] - pst_reg[31:0];
        p1 = ast_reg[31:0] - prt_reg[31:0];
        r2 = frt_reg[31:0] - ast_reg[31:0];
        p2 = fst_reg[31:0] - art_reg[31:0];
        den_c = {2'b0, r1} + {2'b0, r2} + {2'b0, p1} + {2'b0, p2};
        mag = (pa_reg < sr_res[63:0]) ? (sr_res[63:0] - pa_reg) : (pa_reg - sr_res[63:0]);
        qs = 32'd0;
        dq = '0;
        pst_next = pst_reg; prt_next = prt_reg; ast_next = ast_reg;
        art_next = art_reg; fst_next = fst_reg; frt_next = frt_reg;
        pend_next = pend_reg;
        seq_next = seq_reg;
        tmo_next = tmo_reg;
        state_next = state_reg;
        res_next = res_reg;
        ov_next = ov_reg && !m_ready;
        pa_next = pa_reg;
        neg_next = neg_reg;
        den_next = den_reg;
        q_next = q_reg;
        sr_ctl = '{start: 1'b0, op: SR_MULT};
        sr_a = '0;
        sr_b = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next = '0;
                    res_next.next_timeout_ms = tmo_reg;
                    case (s_item.func)
                        FUNC_RX: begin
                            if (s_item.msg_type == MSG_POLL) begin
                                prt_next = rx_t;
                                res_next.send_type = FR_ANSWER;
                                res_next.send_seq = s_item.msg_seq;
                                pend_next = FR_ANSWER;
                            end else if (s_item.msg_type == MSG_ANSWER) begin
                                art_next = rx_t;
                                res_next.send_type = FR_FINAL;
                                res_next.send_seq = s_item.msg_seq;
                                pend_next = FR_FINAL;
                            end else if (s_item.msg_type == MSG_FINAL) begin
                                frt_next = rx_t;
                                res_next.send_type = FR_REPORT;
                                res_next.send_seq = s_item.msg_seq;
                                pend_next = FR_REPORT;
                                res_next.send_poll_rx = prt_reg;
                                res_next.send_answer_tx = ast_reg;
                                res_next.send_final_rx = rx_t;
                            end else if (s_item.msg_type == MSG_REPORT) begin
                                prt_next = s_item.peer_poll_rx;
                                ast_next = s_item.peer_answer_tx;
                                frt_next = s_item.peer_final_rx;
                                res_next.restart_receive = 1'b1;
                                tmo_next = intv_reg;
                                res_next.next_timeout_ms = intv_reg;
                                state_next = ST_MUL1;
                            end
                        end
                        FUNC_TX: begin
                            if (pend_reg == FR_POLL) begin
                                pst_next = tx_t;
                            end else if (pend_reg == FR_ANSWER) begin
                                ast_next = tx_t;
                            end else if (pend_reg == FR_FINAL) begin
                                fst_next = tx_t;
                            end
                        end
                        FUNC_TMO: res_next.restart_receive = 1'b1;
                        FUNC_START: begin
                            seq_next = seq_reg + 8'd1;
                            res_next.send_type = FR_POLL;
                            res_next.send_seq = seq_reg + 8'd1;
                            pend_next = FR_POLL;
                            pst_next = '0; prt_next = '0; ast_next = '0;
                            art_next = '0; fst_next = '0; frt_next = '0;
                            tmo_next = '0;
                            res_next.next_timeout_ms = '0;
                        end
                        FUNC_FAIL: res_next.next_timeout_ms = '0;
                        default: ;
                    endcase
                    if (state_next == ST_IDLE) begin
                        ov_next = 1'b1;
                    end
                end
            end
            ST_MUL1: begin
                den_next = den_c;
                if (den_c == '0) begin
                    state_next = ST_OUT;
                end else begin
                    sr_ctl = '{start: 1'b1, op: SR_MULT};
                    sr_a = {40'd0, r1};
                    sr_b = {2'b0, r2};
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2: begin
                if (sr_sts.done) begin
                    pa_next = sr_res[63:0];
                    sr_ctl = '{start: 1'b1, op: SR_MULT};
                    sr_a = {40'd0, p1};
                    sr_b = {2'b0, p2};
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (sr_sts.done) begin
                    neg_next = pa_reg < sr_res[63:0];
                    sr_ctl = '{start: 1'b1, op: SR_DIVQ8};
                    sr_a = {mag, 8'd0};
                    sr_b = den_reg;
                    state_next = ST_MM;
                end
            end
            ST_MM: begin
                if (sr_sts.done) begin
                    if (neg_reg) begin
                        qs = (sr_big || sr_res[31:0] > 32'h80000000) ?
                             32'h80000000 : sr_res[31:0];
                    end else begin
                        qs = (sr_big || sr_res[31:0] > 32'h7FFFFFFF) ?
                             32'h7FFFFFFF : sr_res[31:0];
                    end
                    q_next = qs;
                    sr_ctl = '{start: 1'b1, op: SR_MULT};
                    sr_a = {40'd0, qs};
                    sr_b = {5'd0, MmNum};
                    state_next = ST_MMDIV;
                end
            end
            ST_MMDIV: begin
                if (sr_sts.done) begin
                    sr_ctl = '{start: 1'b1, op: SR_DIVMM};
                    sr_a = sr_res;
                    sr_b = MmDen;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (den_reg == '0) begin
                    state_next = ST_IDLE;
                    ov_next = 1'b1;
                end else if (sr_sts.done) begin
                    dq = sr_res;
                    res_next.range_valid = 1'b1;
                    if (neg_reg) begin
                        if (dq > 72'd8388608) dq = 72'd8388608;
                        res_next.prop_ticks_q8 = -q_reg;
                        res_next.distance_mm = -dq[23:0];
                    end else begin
                        if (dq > 72'd8388607) dq = 72'd8388607;
                        res_next.prop_ticks_q8 = q_reg;
                        res_next.distance_mm = dq[23:0];
                    end
                    state_next = ST_IDLE;
                    ov_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

/* rtl/core/dtr_checker.sv */
module dtr_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input dtr_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input dtr_pkg::out_item_t m_item
);
    import dtr_pkg::*;
`include "ds_twr_ranging_engine_macros.svh"

    `DTR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))
    `DTR_ASSERT_IMPL(a_no_in_while_out, aclk, aresetn, m_valid, !s_ready)
    `DTR_ASSERT_IMPL(a_range_report, aclk, aresetn, m_valid && m_item.range_valid, m_item.restart_receive && m_item.send_type == FR_NONE)
    `DTR_ASSERT_IMPL(a_no_range_zero, aclk, aresetn, m_valid && !m_item.range_valid, m_item.prop_ticks_q8 == 0 && m_item.distance_mm == 0)
endmodule

bind ds_twr_ranging_engine dtr_checker u_dtr_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_item(s_item), .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
);

/* sim/tb.sv */
module tb;
    import dtr_pkg::*;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t result;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_ANT_DELAY;
    logic [15:0] cfg_data = '0;

    ds_twr_ranging_engine dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state.
    logic [15:0]    ant_delay;
    logic [15:0]    interval_ms;
    logic [TsW-1:0] t_poll_tx, t_poll_rx, t_ans_tx, t_ans_rx, t_fin_tx, t_fin_rx;
    logic [2:0]     queued_frame;
    logic [7:0]     poll_seq;
    logic [15:0]    timeout_now;

    out_item_t   pending_results[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned events_sent = 0;
    bit          calm = 1'b0;

    function automatic bit range_estimate(output logic signed [31:0] q8,
                                          output logic signed [23:0] mm);
        logic [31:0] round1, reply1, round2, reply2;
        logic [63:0] pa, pb, mag, den, q, d;
        logic [71:0] q72;
        bit          neg;
        round1 = t_ans_rx[31:0] - t_poll_tx[31:0];
        reply1 = t_ans_tx[31:0] - t_poll_rx[31:0];
        round2 = t_fin_rx[31:0] - t_ans_tx[31:0];
        reply2 = t_fin_tx[31:0] - t_ans_rx[31:0];
        pa = 64'(round1) * 64'(round2);
        pb = 64'(reply1) * 64'(reply2);
        den = 64'(round1) + 64'(round2) + 64'(reply1) + 64'(reply2);
        q8 = '0;
        mm = '0;
        if (den == 0) begin
            return 1'b0;
        end
        neg = pa < pb;
        mag = neg ? pb - pa : pa - pb;
        q72 = {mag, 8'h00} / 72'(den);
        if (neg) begin
            q = (q72 > 72'h80000000) ? 64'h80000000 : q72[63:0];
        end else begin
            q = (q72 > 72'h7FFFFFFF) ? 64'h7FFFFFFF : q72[63:0];
        end
        d = q * 64'(MmNum) / 64'(MmDen);
        if (neg) begin
            if (d > 64'd8388608) begin
                d = 64'd8388608;
            end
            q8 = -q[31:0];
            mm = -d[23:0];
        end else begin
            if (d > 64'd8388607) begin
                d = 64'd8388607;
            end
            q8 = q[31:0];
            mm = d[23:0];
        end
        return 1'b1;
    endfunction

    function automatic out_item_t predict_event(in_item_t it);
        out_item_t      r;
        logic [TsW-1:0] half, rx_t, tx_t;
        r = '0;
        half = TsW'(ant_delay >> 1);
        rx_t = it.event_time - half;
        tx_t = it.event_time + half;
        r.next_timeout_ms = timeout_now;
        case (it.func)
            FUNC_RX: begin
                if (it.msg_type == MSG_POLL) begin
                    t_poll_rx = rx_t;
                    r.send_type = FR_ANSWER;
                    r.send_seq = it.msg_seq;
                    queued_frame = FR_ANSWER;
                end else if (it.msg_type == MSG_ANSWER) begin
                    t_ans_rx = rx_t;
                    r.send_type = FR_FINAL;
                    r.send_seq = it.msg_seq;
                    queued_frame = FR_FINAL;
                end else if (it.msg_type == MSG_FINAL) begin
                    t_fin_rx = rx_t;
                    r.send_type = FR_REPORT;
                    r.send_seq = it.msg_seq;
                    queued_frame = FR_REPORT;
                    r.send_poll_rx = t_poll_rx;
                    r.send_answer_tx = t_ans_tx;
                    r.send_final_rx = t_fin_rx;
                end else if (it.msg_type == MSG_REPORT) begin
                    t_poll_rx = it.peer_poll_rx;
                    t_ans_tx = it.peer_answer_tx;
                    t_fin_rx = it.peer_final_rx;
                    r.range_valid = range_estimate(r.prop_ticks_q8, r.distance_mm);
                    r.restart_receive = 1'b1;
                    timeout_now = interval_ms;
                end
                r.next_timeout_ms = timeout_now;
            end
            FUNC_TX: begin
                if (queued_frame == FR_POLL) begin
                    t_poll_tx = tx_t;
                end else if (queued_frame == FR_ANSWER) begin
                    t_ans_tx = tx_t;
                end else if (queued_frame == FR_FINAL) begin
                    t_fin_tx = tx_t;
                end
            end
            FUNC_TMO: begin
                r.restart_receive = 1'b1;
            end
            FUNC_START: begin
                poll_seq = poll_seq + 8'd1;
                r.send_type = FR_POLL;
                r.send_seq = poll_seq;
                queued_frame = FR_POLL;
                {t_poll_tx, t_poll_rx, t_ans_tx, t_ans_rx, t_fin_tx, t_fin_rx} = '0;
                timeout_now = '0;
                r.next_timeout_ms = '0;
            end
            FUNC_FAIL: begin
                r.next_timeout_ms = '0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic in_item_t make_event(logic [2:0] f, logic [7:0] ty, logic [7:0] sq,
                                            logic [TsW-1:0] t, logic [TsW-1:0] a = '0,
                                            logic [TsW-1:0] b = '0, logic [TsW-1:0] c = '0);
        in_item_t it;
        it.func = f;
        it.msg_type = ty;
        it.msg_seq = sq;
        it.event_time = t;
        it.peer_poll_rx = a;
        it.peer_answer_tx = b;
        it.peer_final_rx = c;
        return it;
    endfunction

    function automatic logic [TsW-1:0] rand_ts();
        return TsW'({$urandom(), $urandom()});
    endfunction

    task automatic send_event(in_item_t it, bit typed = 1'b0, out_item_t result = '0);
        out_item_t predicted;
        while (!calm && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predicted = predict_event(it);
        pending_results.push_back(typed ? result : predicted);
        events_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(logic idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ANT_DELAY) begin
            ant_delay = value;
        end else begin
            interval_ms = value;
        end
        @(posedge aclk);
    endtask

    // Initiator exchange, plausible timestamps; broken may add faults.
    task automatic initiator_exchange(bit broken);
        logic [TsW-1:0] t0, prx, atx, arx, ftx, frx;
        int unsigned    prop;
        prop = $urandom_range(3000);
        t0 = rand_ts();
        prx = t0 + TsW'(prop);
        atx = prx + TsW'($urandom_range(1 << 22));
        arx = atx + TsW'(prop);
        ftx = arx + TsW'($urandom_range(1 << 22));
        frx = ftx + TsW'(prop);
        send_event(make_event(FUNC_START, 8'($urandom), 8'($urandom), rand_ts()));
        send_event(make_event(FUNC_TX, 8'($urandom), 8'($urandom), t0));
        if (broken && $urandom_range(1)) begin
            send_event(make_event(FUNC_TMO, 8'($urandom), 8'($urandom), rand_ts()));
        end
        send_event(make_event(FUNC_RX, MSG_ANSWER, 8'($urandom), arx));
        if (!(broken && $urandom_range(1))) begin
            send_event(make_event(FUNC_TX, 8'($urandom), 8'($urandom), ftx));
        end
        send_event(make_event(FUNC_RX, MSG_REPORT, 8'($urandom), rand_ts(), prx, atx, frx));
    endtask

    task automatic responder_exchange();
        logic [TsW-1:0] t;
        t = rand_ts();
        send_event(make_event(FUNC_RX, MSG_POLL, 8'($urandom), t));
        t = t + TsW'($urandom_range(1 << 20));
        send_event(make_event(FUNC_TX, 8'($urandom), 8'($urandom), t));
        t = t + TsW'($urandom_range(1 << 20));
        send_event(make_event(FUNC_RX, MSG_FINAL, 8'($urandom), t));
        send_event(make_event(FUNC_TX, 8'($urandom), 8'($urandom),
                              t + TsW'($urandom_range(1 << 20))));
    endtask

    task automatic random_phase(int unsigned goal);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = events_sent + goal;
        while (events_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                initiator_exchange(pick < 10);
            end else if (pick < 80) begin
                responder_exchange();
            end else if (pick < 90) begin
                send_event(make_event(3'($urandom_range(7)), 8'($urandom_range(5)),
                                      8'($urandom), rand_ts(), rand_ts(), rand_ts(),
                                      rand_ts()));
            end else begin
                send_event(make_event(3'($urandom), 8'($urandom), 8'($urandom),
                                      rand_ts(), rand_ts(), rand_ts(), rand_ts()));
            end
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result item: %p", m_item);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_item.send_type !== want.send_type
                        || m_item.send_seq !== want.send_seq
                        || m_item.send_poll_rx !== want.send_poll_rx
                        || m_item.send_answer_tx !== want.send_answer_tx
                        || m_item.send_final_rx !== want.send_final_rx
                        || m_item.range_valid !== want.range_valid
                        || m_item.prop_ticks_q8 !== want.prop_ticks_q8
                        || m_item.distance_mm !== want.distance_mm
                        || m_item.restart_receive !== want.restart_receive
                        || m_item.next_timeout_ms !== want.next_timeout_ms) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Result mismatch: expected %p", want);
                        $display("                 actual   %p", m_item);
                    end
                end
            end
        end
        m_ready <= calm || ($urandom_range(99) >= 17);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        out_item_t r;
        logic [15:0] delays[6];
        logic [15:0] intervals[6];
        ant_delay = 16'd32951;
        interval_ms = 16'd4000;
        {t_poll_tx, t_poll_rx, t_ans_tx, t_ans_rx, t_fin_tx, t_fin_rx} = '0;
        queued_frame = FR_NONE;
        poll_seq = '0;
        timeout_now = '0;

        row.typed = 1'b1;
        r = '0;
        row.item = make_event(FUNC_RX, 8'h00, 8'hFF, '1, '1, '1, '1);
        row.result = r;
        rows.push_back(row);
        row.item = make_event(FUNC_FAIL, 8'hFF, 8'hFF, '1);
        rows.push_back(row);
        row.item = make_event(FUNC_RX, 8'hFF, 8'h00, '0);
        rows.push_back(row);
        row.item = make_event(FUNC_TX, 8'h00, 8'h00, '1);
        rows.push_back(row);
        r.restart_receive = 1'b1;
        row.item = make_event(FUNC_TMO, 8'h00, 8'h00, '0);
        row.result = r;
        rows.push_back(row);
        r = '0;
        r.send_type = FR_POLL;
        r.send_seq = 8'd1;
        row.item = make_event(FUNC_START, 8'hFF, 8'hFF, '1);
        row.result = r;
        rows.push_back(row);
        row.typed = 1'b0;
        row.item = make_event(FUNC_TX, 8'h00, 8'h00, '1);
        rows.push_back(row);
        row.item = make_event(FUNC_RX, MSG_ANSWER, 8'hFF, '0);
        rows.push_back(row);
        row.item = make_event(FUNC_TX, 8'h00, 8'h00, 40'h00_0010_0000);
        rows.push_back(row);
        row.item = make_event(FUNC_RX, MSG_REPORT, 8'h00, '0, 40'h1000, 40'h8_1000,
                              40'h20_0000);
        rows.push_back(row);
        row.item = make_event(FUNC_RX, MSG_POLL, 8'h5A, 40'h0);
        rows.push_back(row);
        row.item = make_event(FUNC_TX, 8'h00, 8'h00, 40'hFF_FFFF_FF00);
        rows.push_back(row);
        row.item = make_event(FUNC_RX, MSG_FINAL, 8'hA5, 40'h00_0000_1234);
        rows.push_back(row);
        row.item = make_event(FUNC_TX, 8'h00, 8'h00, '1);
        rows.push_back(row);
        row.item = make_event(3'd5, 8'h00, 8'h00, '0);
        rows.push_back(row);
        row.item = make_event(3'd7, MSG_REPORT, 8'h00, '1, '1, '1, '1);
        rows.push_back(row);
        row.item = make_event(FUNC_START, 8'h00, 8'h00, '0);
        rows.push_back(row);
        // A report over all-zero timestamps has a zero denominator.
        row.typed = 1'b1;
        r = '0;
        r.restart_receive = 1'b1;
        r.next_timeout_ms = 16'd4000;
        row.item = make_event(FUNC_RX, MSG_REPORT, 8'h00, '0);
        row.result = r;
        rows.push_back(row);
        row.typed = 1'b0;
        row.item = make_event(FUNC_START, 8'h00, 8'h00, '0);
        rows.push_back(row);
        row.item = make_event(FUNC_RX, MSG_REPORT, 8'h00, '0, '1, '0, '1);
        rows.push_back(row);
        row.item = make_event(FUNC_RX, MSG_REPORT, 8'h00, '0, '0, '1, '0);
        rows.push_back(row);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            send_event(rows[i].item, rows[i].typed, rows[i].result);
        end

        delays = '{16'd0, 16'd65535, 16'd1, 16'd32951, 16'd65534, 16'd0};
        intervals = '{16'd65535, 16'd0, 16'd1234, 16'd4000, 16'd0, 16'd65535};
        for (int p = 0; p < 6; p++) begin
            drain_results();
            write_register(CFG_ANT_DELAY, p == 3 ? 16'($urandom) : delays[p]);
            write_register(CFG_INTERVAL, intervals[p]);
            calm = (p == 2);
            random_phase(145);
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (300) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
